/* hdl/tcsw_pkg.sv */
// Shared types, constants and helpers for the terminal cell screen writer.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package tcsw_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int TAB_STOP    = 8;

  localparam logic [15:0] GLYPH_SPACE  = 16'h0020;
  localparam logic [23:0] RST_FG       = 24'hC0C0C0;
  localparam logic [23:0] RST_BG       = 24'h000000;
  localparam int          RST_COLUMNS  = 80;
  localparam int          RST_ROWS     = 32;

  // item modes
  localparam logic [1:0] MODE_PUT  = 2'd0;
  localparam logic [1:0] MODE_CMD  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_COLUMNS = 3'd0;
  localparam logic [2:0] REG_ROWS    = 3'd1;
  localparam logic [2:0] REG_DEF_FG  = 3'd2;
  localparam logic [2:0] REG_DEF_BG  = 3'd3;
  localparam logic [2:0] REG_AMBIG   = 3'd4;

  // control characters
  localparam logic [15:0] CH_BS         = 16'h0008;
  localparam logic [15:0] CH_TAB        = 16'h0009;
  localparam logic [15:0] CH_LF         = 16'h000A;
  localparam logic [15:0] CH_CR         = 16'h000D;
  localparam logic [15:0] CH_FIRST_PRNT = 16'h0020;

  // command letters
  localparam logic [7:0] CMD_ERASE_SCR  = 8'h4A; // J
  localparam logic [7:0] CMD_ERASE_LINE = 8'h4B; // K
  localparam logic [7:0] CMD_POS        = 8'h48; // H
  localparam logic [7:0] CMD_POS_ALT    = 8'h66; // f
  localparam logic [7:0] CMD_UP         = 8'h41; // A
  localparam logic [7:0] CMD_DOWN       = 8'h42; // B
  localparam logic [7:0] CMD_RIGHT      = 8'h43; // C
  localparam logic [7:0] CMD_LEFT       = 8'h44; // D
  localparam logic [7:0] CMD_COL        = 8'h47; // G
  localparam logic [7:0] CMD_COL_ALT    = 8'h60; // backquote
  localparam logic [7:0] CMD_ROW        = 8'h64; // d

  localparam logic [15:0] ERASE_TO_END   = 16'd0;
  localparam logic [15:0] ERASE_TO_START = 16'd1;
  localparam logic [15:0] ERASE_ALL      = 16'd2;

  typedef struct packed {
    logic [15:0] glyph;
    logic        bold;
    logic        trail;
    logic [23:0] fg;
    logic [23:0] bg;
  } cell_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] char_code;
    logic [7:0]  command_letter;
    logic [15:0] arg_first;
    logic [15:0] arg_second;
    logic [23:0] text_color;
    logic [23:0] paper_color;
    logic        bold_flag;
    logic [6:0]  read_column;
    logic [5:0]  read_row;
  } item_t;

  typedef struct packed {
    logic [15:0] cell_glyph;
    logic [23:0] cell_text_color;
    logic [23:0] cell_paper_color;
    logic        cell_bold;
    logic        cell_is_trailer;
    logic [6:0]  cursor_column;
    logic [5:0]  cursor_line;
  } result_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_RD_WAIT, S_DONE,
    S_NORM_A, S_NORM_B,
    S_CP0, S_CP1, S_CP2, S_CP3, S_SW_NEXT,
    S_SC_START, S_SC_RD, S_SC_WR, S_SB_RD, S_SB_WR,
    S_MR0, S_MR1, S_ML0, S_ML1,
    S_PC1, S_PC2, S_PC3, S_PC4, S_PC5
  } state_e;

  // 1 when the glyph takes two columns
  function automatic logic glyph_wide(input logic [15:0] c, input logic amb);
    logic east;
    logic ambig;
    east = (c >= 16'h1100 && c <= 16'h11FF) || (c >= 16'h3130 && c <= 16'h318F) ||
           (c >= 16'hAC00 && c <= 16'hD7A3) || (c == 16'h3000) ||
           (c >= 16'h4E00 && c <= 16'h9FFF);
    ambig = (c >= 16'h2500 && c <= 16'h257F) || (c >= 16'h25A0 && c <= 16'h25FF) ||
            (c >= 16'h2190 && c <= 16'h21FF) || (c >= 16'h2200 && c <= 16'h22FF) ||
            (c >= 16'h2460 && c <= 16'h24FF) || (c >= 16'h2600 && c <= 16'h26FF) ||
            (c >= 16'h2700 && c <= 16'h27BF) || (c >= 16'h2E80 && c <= 16'hA4CF) ||
            (c >= 16'hFE10 && c <= 16'hFE19) || (c >= 16'hFE30 && c <= 16'hFE6F) ||
            (c >= 16'hFF01 && c <= 16'hFF60) || (c >= 16'hFFE0 && c <= 16'hFFE6);
    return (c > 16'h007F) && (east || (ambig && amb));
  endfunction

endpackage

`default_nettype wire

/* hdl/tcsw_if.sv */
// Handshake channels of the screen writer: item, result and configuration.
// Depends on tcsw_pkg for the payload types.
`default_nettype none

interface tcsw_item_if;
  logic            valid;
  logic            ready;
  tcsw_pkg::item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tcsw_result_if;
  logic              valid;
  logic              ready;
  tcsw_pkg::result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tcsw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/tcsw_cell_mem.sv */
// Cell store: one synchronous memory, one write and one read port, with registered read data.
// Depends on tcsw_pkg for the cell type.
`default_nettype none

module tcsw_cell_mem #(
  parameter int AddrWidth = 13
) (
  input  wire logic                 clk_i,
  input  wire logic                 re_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire tcsw_pkg::cell_t      wdata_i,
  output tcsw_pkg::cell_t           rdata_o
);
  import tcsw_pkg::*;

  localparam int Depth = 1 << AddrWidth;

  cell_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/tcsw_seq.sv */
// Sequencer of the screen writer: cursor, configuration, and the read-modify-write
// programs for put-char, commands, scroll and erase. Depends on tcsw_pkg, tcsw_if.
`default_nettype none

module tcsw_seq #(
  parameter int MaxColumns = tcsw_pkg::MAX_COLUMNS,
  parameter int MaxRows    = tcsw_pkg::MAX_ROWS,
  parameter int XW         = $clog2(MaxColumns),
  parameter int YW         = $clog2(MaxRows)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  tcsw_item_if.sink            item_i,
  tcsw_result_if.source        result_o,
  tcsw_cfg_if.sink             cfg_i,
  output logic                 mem_re_o,
  output logic [XW+YW-1:0]     mem_raddr_o,
  output logic                 mem_we_o,
  output logic [XW+YW-1:0]     mem_waddr_o,
  output tcsw_pkg::cell_t      mem_wdata_o,
  input  wire tcsw_pkg::cell_t mem_rdata_i
);
  import tcsw_pkg::*;

  localparam int XN = XW + 1;
  localparam int YN = YW + 1;
  localparam int AW = XW + YW;
  localparam int RstCols = (MaxColumns < RST_COLUMNS) ? MaxColumns : RST_COLUMNS;
  localparam int RstRows = (MaxRows < RST_ROWS) ? MaxRows : RST_ROWS;

  state_e state_q, state_d, ret_q, ret_d;
  logic [XN-1:0] cx_q, cx_d, cols_q, cols_d, wx_q, wx_d, ex_q, ex_d, tx_q, tx_d;
  logic [XN-1:0] tstop_q, tstop_d;
  logic [YN-1:0] cy_q, cy_d, rows_q, rows_d, wy_q, wy_d, ey_q, ey_d;
  logic [23:0]   dfg_q, dfg_d, dbg_q, dbg_d;
  logic          amb_q, amb_d, tabm_q, tabm_d, t0_q, t0_d;
  logic [15:0]   cnt_q, cnt_d;
  item_t         item_q, item_d;
  cell_t         cell_q, cell_d;
  result_t       res_q, res_d;
  logic          res_v_q, res_v_d;
  logic [AW-1:0] clr_q, clr_d;

  logic [XN-1:0] colm1;
  logic [YN-1:0] rowm1;
  logic [15:0]   n1, n2;
  logic          wide;
  logic          rd_in_area;
  logic [XN-1:0] rd_x;
  logic [YN-1:0] rd_y;
  cell_t         blank;
  logic          mv_exit_norm;

  function automatic logic [AW-1:0] addr(input logic [XN-1:0] x, input logic [YN-1:0] y);
    return {y[YW-1:0], x[XW-1:0]};
  endfunction

  function automatic logic [XN-1:0] clamp_x(input logic [15:0] a, input logic [XN-1:0] lim);
    logic [15:0] v;
    v = a - 16'd1;
    if (v >= 16'(lim)) return lim - 1'b1;
    return XN'(v);
  endfunction

  function automatic logic [YN-1:0] clamp_y(input logic [15:0] a, input logic [YN-1:0] lim);
    logic [15:0] v;
    v = a - 16'd1;
    if (v >= 16'(lim)) return lim - 1'b1;
    return YN'(v);
  endfunction

  assign colm1 = cols_q - 1'b1;
  assign rowm1 = rows_q - 1'b1;
  assign n1 = (item_q.arg_first == 16'd0) ? 16'd1 : item_q.arg_first;
  assign n2 = (item_q.arg_second == 16'd0) ? 16'd1 : item_q.arg_second;
  assign wide = glyph_wide(item_q.char_code, amb_q);
  assign rd_in_area = (16'(item_q.read_column) < 16'(cols_q)) &&
                      (16'(item_q.read_row) < 16'(rows_q));
  assign rd_x = XN'(item_q.read_column);
  assign rd_y = YN'(item_q.read_row);
  assign mv_exit_norm = (item_q.mode == MODE_CMD);
  always_comb begin
    blank = '0;
    blank.glyph = GLYPH_SPACE;
    blank.fg = dfg_q;
    blank.bg = dbg_q;
  end

  // next state and datapath
  always_comb begin
    logic [XN:0]   xsum;
    logic [16:0]   ysum;
    logic          cont;
    state_d = state_q;
    ret_d   = ret_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cols_d  = cols_q;
    rows_d  = rows_q;
    wx_d    = wx_q;
    wy_d    = wy_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    tx_d    = tx_q;
    tstop_d = tstop_q;
    dfg_d   = dfg_q;
    dbg_d   = dbg_q;
    amb_d   = amb_q;
    tabm_d  = tabm_q;
    t0_d    = t0_q;
    cnt_d   = cnt_q;
    item_d  = item_q;
    cell_d  = cell_q;
    res_d   = res_q;
    res_v_d = res_v_q;
    clr_d   = clr_q;
    xsum    = '0;
    ysum    = '0;
    cont    = 1'b0;

    if (result_o.valid && result_o.ready) res_v_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (item_i.valid) begin
          item_d  = item_i.data;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cell_d  = '0;
        state_d = S_DONE;
        case (item_q.mode)
          MODE_PUT: begin
            if (item_q.char_code == CH_CR) begin
              cx_d = '0;
            end else if (item_q.char_code == CH_LF) begin
              if (17'(cy_q) + 17'd1 >= 17'(rows_q)) begin
                cy_d    = rowm1;
                ret_d   = S_DONE;
                state_d = S_SC_START;
              end else begin
                cy_d = cy_q + 1'b1;
              end
            end else if (item_q.char_code == CH_BS) begin
              cnt_d   = 16'd1;
              state_d = S_ML0;
            end else if (item_q.char_code == CH_TAB) begin
              tabm_d  = 1'b1;
              cnt_d   = '0;
              tstop_d = (cx_q + XN'(TAB_STOP)) & ~XN'(TAB_STOP - 1);
              state_d = S_MR0;
            end else if (item_q.char_code >= CH_FIRST_PRNT) begin
              state_d = S_NORM_A;
            end
          end
          MODE_CMD: begin
            case (item_q.command_letter)
              CMD_ERASE_SCR: begin
                ret_d = S_SW_NEXT;
                if (item_q.arg_first == ERASE_TO_END) begin
                  wx_d = cx_q; wy_d = cy_q; ex_d = colm1; ey_d = rowm1;
                  state_d = S_CP0;
                end else if (item_q.arg_first == ERASE_TO_START) begin
                  wx_d = '0; wy_d = '0; ex_d = cx_q; ey_d = cy_q;
                  state_d = S_CP0;
                end else if (item_q.arg_first == ERASE_ALL) begin
                  wx_d = '0; wy_d = '0; ex_d = colm1; ey_d = rowm1;
                  cx_d = '0; cy_d = '0;
                  state_d = S_CP0;
                end
              end
              CMD_ERASE_LINE: begin
                ret_d = S_SW_NEXT;
                wy_d  = cy_q;
                ey_d  = cy_q;
                if (item_q.arg_first == ERASE_TO_END) begin
                  wx_d = cx_q; ex_d = colm1; state_d = S_CP0;
                end else if (item_q.arg_first == ERASE_TO_START) begin
                  wx_d = '0; ex_d = cx_q; state_d = S_CP0;
                end else if (item_q.arg_first == ERASE_ALL) begin
                  wx_d = '0; ex_d = colm1; state_d = S_CP0;
                end
              end
              CMD_POS, CMD_POS_ALT: begin
                cy_d = clamp_y(n1, rows_q);
                cx_d = clamp_x(n2, cols_q);
                state_d = S_NORM_A;
              end
              CMD_UP: begin
                if (n1 >= 16'(cy_q)) cy_d = '0;
                else cy_d = cy_q - YN'(n1);
                state_d = S_NORM_A;
              end
              CMD_DOWN: begin
                ysum = 17'(cy_q) + 17'(n1);
                if (ysum >= 17'(rows_q)) cy_d = rowm1;
                else cy_d = YN'(ysum);
                state_d = S_NORM_A;
              end
              CMD_RIGHT: begin
                tabm_d = 1'b0; cnt_d = n1; state_d = S_MR0;
              end
              CMD_LEFT: begin
                cnt_d = n1; state_d = S_ML0;
              end
              CMD_COL, CMD_COL_ALT: begin
                cx_d = clamp_x(n1, cols_q);
                state_d = S_NORM_A;
              end
              CMD_ROW: begin
                cy_d = clamp_y(n1, rows_q);
                state_d = S_NORM_A;
              end
              default: state_d = S_DONE;
            endcase
          end
          MODE_READ: begin
            if (rd_in_area) begin
              state_d = S_RD_WAIT;
            end else begin
              cell_d = blank;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RD_WAIT: begin
        cell_d  = mem_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!res_v_q || result_o.ready) begin
          res_d.cell_glyph       = cell_q.glyph;
          res_d.cell_text_color  = cell_q.fg;
          res_d.cell_paper_color = cell_q.bg;
          res_d.cell_bold        = cell_q.bold;
          res_d.cell_is_trailer  = cell_q.trail;
          res_d.cursor_column    = 7'(cx_q);
          res_d.cursor_line      = 6'(cy_q);
          res_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      // step back off the right half of a wide glyph
      S_NORM_A: begin
        if (cx_q != '0) state_d = S_NORM_B;
        else state_d = (item_q.mode == MODE_PUT) ? S_PC1 : S_DONE;
      end
      S_NORM_B: begin
        if (mem_rdata_i.trail) cx_d = cx_q - 1'b1;
        state_d = (item_q.mode == MODE_PUT) ? S_PC1 : S_DONE;
      end
      // clear the pair around (wx, wy)
      S_CP0: state_d = S_CP1;
      S_CP1: begin
        t0_d    = mem_rdata_i.trail;
        state_d = S_CP2;
      end
      S_CP2: begin
        state_d = ret_q;
        if (t0_q) begin
          if (wx_q != '0) begin
            tx_d = wx_q - 1'b1; state_d = S_CP3;
          end
        end else if ((wx_q + 1'b1 < cols_q) && mem_rdata_i.trail) begin
          tx_d = wx_q + 1'b1; state_d = S_CP3;
        end
      end
      S_CP3: state_d = ret_q;
      S_SW_NEXT: begin
        if (wx_q == ex_q && wy_q == ey_q) begin
          state_d = S_DONE;
        end else if (wx_q == colm1) begin
          wx_d = '0; wy_d = wy_q + 1'b1; state_d = S_CP0;
        end else begin
          wx_d = wx_q + 1'b1; state_d = S_CP0;
        end
      end
      // scroll up: copy rows, then refresh the bottom row
      S_SC_START: begin
        wx_d = '0;
        if (rows_q > YN'(1)) begin
          wy_d = YN'(1); state_d = S_SC_RD;
        end else begin
          wy_d = rowm1; state_d = S_SB_RD;
        end
      end
      S_SC_RD: state_d = S_SC_WR;
      S_SC_WR: begin
        if (wx_q == colm1) begin
          wx_d = '0;
          if (wy_q == rowm1) state_d = S_SB_RD;
          else begin
            wy_d = wy_q + 1'b1; state_d = S_SC_RD;
          end
        end else begin
          wx_d = wx_q + 1'b1; state_d = S_SC_RD;
        end
      end
      S_SB_RD: state_d = S_SB_WR;
      S_SB_WR: begin
        if (wx_q == colm1) state_d = ret_q;
        else begin
          wx_d = wx_q + 1'b1; state_d = S_SB_RD;
        end
      end
      S_MR0: begin
        cont = tabm_q ? ((cx_q < tstop_q) && (cx_q < colm1)) : (cnt_q != '0);
        if (!cont) begin
          state_d = mv_exit_norm ? S_NORM_A : S_DONE;
        end else if (cx_q >= colm1) begin
          cx_d = colm1;
          state_d = mv_exit_norm ? S_NORM_A : S_DONE;
        end else begin
          state_d = S_MR1;
        end
      end
      S_MR1: begin
        xsum = (XN+1)'(cx_q) + (mem_rdata_i.trail ? (XN+1)'(2) : (XN+1)'(1));
        if (xsum >= (XN+1)'(cols_q)) cx_d = colm1;
        else cx_d = XN'(xsum);
        if (!tabm_q) cnt_d = cnt_q - 1'b1;
        state_d = S_MR0;
      end
      S_ML0: begin
        if (cnt_q == '0 || cx_q == '0) begin
          state_d = mv_exit_norm ? S_NORM_A : S_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
          cx_d  = cx_q - 1'b1;
          if (cx_q > XN'(1)) state_d = S_ML1;
        end
      end
      S_ML1: begin
        if (mem_rdata_i.trail) cx_d = cx_q - 1'b1;
        state_d = S_ML0;
      end
      // printable glyph
      S_PC1: begin
        xsum = (XN+1)'(cx_q) + (wide ? (XN+1)'(2) : (XN+1)'(1));
        state_d = S_PC2;
        if (xsum > (XN+1)'(cols_q)) begin
          cx_d = '0;
          if (17'(cy_q) + 17'd1 >= 17'(rows_q)) begin
            cy_d = rowm1; ret_d = S_PC2; state_d = S_SC_START;
          end else begin
            cy_d = cy_q + 1'b1;
          end
        end
      end
      S_PC2: begin
        wx_d = cx_q; wy_d = cy_q; ret_d = S_PC3; state_d = S_CP0;
      end
      S_PC3: begin
        if (wide && (cx_q + 1'b1 < cols_q)) begin
          wx_d = cx_q + 1'b1; ret_d = S_PC4; state_d = S_CP0;
        end else begin
          state_d = S_PC4;
        end
      end
      S_PC4: begin
        state_d = S_DONE;
        if (!wide) begin
          if (cx_q + 1'b1 >= cols_q) cx_d = colm1;
          else cx_d = cx_q + 1'b1;
        end else if (cx_q + 1'b1 < cols_q) begin
          state_d = S_PC5;
        end
      end
      S_PC5: begin
        xsum = (XN+1)'(cx_q) + (XN+1)'(2);
        if (xsum >= (XN+1)'(cols_q)) cx_d = colm1;
        else cx_d = XN'(xsum);
        state_d = S_DONE;
      end
      default: state_d = S_IDLE;
    endcase

    // the user is to send configuration words only while idle; the block does not enforce this
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_COLUMNS: begin
          if (cfg_i.data[7:0] == 8'd0) cols_d = XN'(1);
          else if (16'(cfg_i.data[7:0]) > 16'(MaxColumns)) cols_d = XN'(MaxColumns);
          else cols_d = XN'(cfg_i.data[7:0]);
        end
        REG_ROWS: begin
          if (cfg_i.data[6:0] == 7'd0) rows_d = YN'(1);
          else if (16'(cfg_i.data[6:0]) > 16'(MaxRows)) rows_d = YN'(MaxRows);
          else rows_d = YN'(cfg_i.data[6:0]);
        end
        REG_DEF_FG: dfg_d = cfg_i.data;
        REG_DEF_BG: dbg_d = cfg_i.data;
        REG_AMBIG:  amb_d = cfg_i.data[0];
        default: ;
      endcase
      if (cfg_i.index <= REG_AMBIG) begin
        if (cx_d >= cols_d) cx_d = cols_d - 1'b1;
        if (cy_d >= rows_d) cy_d = rows_d - 1'b1;
      end
    end
  end

  // handshakes and memory port
  always_comb begin
    item_i.ready    = (state_q == S_IDLE);
    cfg_i.ready     = 1'b1;
    result_o.valid  = res_v_q;
    result_o.data   = res_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr(wx_q, wy_q);
    mem_we_o    = 1'b0;
    mem_waddr_o = addr(wx_q, wy_q);
    mem_wdata_o = blank;
    case (state_q)
      S_CLEAR: begin
        mem_we_o          = 1'b1;
        mem_waddr_o       = clr_q;
        mem_wdata_o       = '0;
        mem_wdata_o.glyph = GLYPH_SPACE;
        mem_wdata_o.fg    = RST_FG;
        mem_wdata_o.bg    = RST_BG;
      end
      S_DISPATCH: begin
        mem_re_o    = (item_q.mode == MODE_READ) && rd_in_area;
        mem_raddr_o = addr(rd_x, rd_y);
      end
      S_NORM_A: begin
        mem_re_o    = (cx_q != '0);
        mem_raddr_o = addr(cx_q, cy_q);
      end
      S_CP0, S_SC_RD, S_SB_RD: mem_re_o = 1'b1;
      S_CP1: begin
        mem_re_o    = (wx_q + 1'b1 < cols_q);
        mem_raddr_o = addr(wx_q + 1'b1, wy_q);
      end
      S_CP2: mem_we_o = 1'b1;
      S_CP3: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr(tx_q, wy_q);
      end
      S_SC_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr(wx_q, wy_q - 1'b1);
        mem_wdata_o = mem_rdata_i;
      end
      S_SB_WR: begin
        mem_we_o          = 1'b1;
        mem_wdata_o       = mem_rdata_i;
        mem_wdata_o.glyph = GLYPH_SPACE;
        mem_wdata_o.bg    = dbg_q;
        mem_wdata_o.trail = 1'b0;
      end
      S_MR0: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = addr(cx_q + 1'b1, cy_q);
      end
      S_ML0: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = addr(cx_q - 1'b1, cy_q);
      end
      S_PC4: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr(cx_q, cy_q);
        if (!wide || (cx_q + 1'b1 < cols_q)) begin
          mem_wdata_o.glyph = item_q.char_code;
          mem_wdata_o.fg    = item_q.text_color;
          mem_wdata_o.bg    = item_q.paper_color;
          mem_wdata_o.bold  = item_q.bold_flag;
          mem_wdata_o.trail = 1'b0;
        end
      end
      S_PC5: begin
        mem_we_o          = 1'b1;
        mem_waddr_o       = addr(cx_q + 1'b1, cy_q);
        mem_wdata_o.glyph = GLYPH_SPACE;
        mem_wdata_o.fg    = item_q.text_color;
        mem_wdata_o.bg    = item_q.paper_color;
        mem_wdata_o.bold  = item_q.bold_flag;
        mem_wdata_o.trail = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_DONE;
      cx_q    <= '0;
      cy_q    <= '0;
      cols_q  <= XN'(RstCols);
      rows_q  <= YN'(RstRows);
      dfg_q   <= RST_FG;
      dbg_q   <= RST_BG;
      amb_q   <= 1'b0;
      tabm_q  <= 1'b0;
      res_v_q <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      cols_q  <= cols_d;
      rows_q  <= rows_d;
      dfg_q   <= dfg_d;
      dbg_q   <= dbg_d;
      amb_q   <= amb_d;
      tabm_q  <= tabm_d;
      res_v_q <= res_v_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q    <= wx_d;
    wy_q    <= wy_d;
    ex_q    <= ex_d;
    ey_q    <= ey_d;
    tx_q    <= tx_d;
    tstop_q <= tstop_d;
    t0_q    <= t0_d;
    cnt_q   <= cnt_d;
    item_q  <= item_d;
    cell_q  <= cell_d;
    res_q   <= res_d;
  end

endmodule

`default_nettype wire

/* hdl/terminal_cell_screen_writer_top.sv */
// Terminal cell screen writer: a text screen of glyph/color cells with a cursor.
// Channels: item_i takes one word per character, command or cell read; result_o
// returns one word per item (read cell, zero outside reads, and the cursor after it);
// cfg_i writes screen size, default colors and the ambiguous-width option, and is
// always ready. Words move when valid and ready are both high.
// One item is worked at a time by a sequencer around a single-port-read cell memory
// (registered read data). Multi-cell moves and tabs step one cell at a time and
// erase clears cell by cell; a printable glyph that wraps on the bottom row, and a
// line feed there, scroll the active area up by one row.
// After reset the memory is swept to blank cells, one cell a cycle, over all
// 2^(clog2(MaxColumns)+clog2(MaxRows)) cells (8192 by default); no item is taken
// then, configuration words are. A finished result waits in an output register,
// so a stalled receiver holds that word and the next item is taken and worked;
// its result waits for the register to free.
`default_nettype none

module terminal_cell_screen_writer_top #(
  parameter int MaxColumns = tcsw_pkg::MAX_COLUMNS,
  parameter int MaxRows    = tcsw_pkg::MAX_ROWS
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  tcsw_item_if.sink     item_i,
  tcsw_result_if.source result_o,
  tcsw_cfg_if.sink      cfg_i
);
  import tcsw_pkg::*;

  localparam int XW = $clog2(MaxColumns);
  localparam int YW = $clog2(MaxRows);
  localparam int AW = XW + YW;

  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  cell_t         mem_wdata, mem_rdata;

  tcsw_seq #(
    .MaxColumns(MaxColumns),
    .MaxRows   (MaxRows),
    .XW        (XW),
    .YW        (YW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .result_o   (result_o),
    .cfg_i      (cfg_i),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  tcsw_cell_mem #(
    .AddrWidth(AW)
  ) u_mem (
    .clk_i  (clk_i),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for the terminal cell screen writer: it drives characters,
// commands and cell reads and checks every result word against a cell-level screen model.
// Depends on tcsw_pkg, tcsw_if and terminal_cell_screen_writer_top.
`default_nettype none

module testbench;
  import tcsw_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int CYCLE_LIMIT = 4000000;

  class screen_scoreboard;
    logic [15:0] glyph_m [CELL_COUNT];
    logic [23:0] fg_m [CELL_COUNT];
    logic [23:0] bg_m [CELL_COUNT];
    bit bold_m [CELL_COUNT];
    bit trail_m [CELL_COUNT];
    int cols;
    int rows;
    logic [23:0] dfg;
    logic [23:0] dbg;
    bit amb;
    int cx;
    int cy;
    result_t due[$];
    int errors;
    int checked;

    function new();
      cols = RST_COLUMNS;
      rows = RST_ROWS;
      dfg = RST_FG;
      dbg = RST_BG;
      amb = 0;
      cx = 0;
      cy = 0;
      errors = 0;
      checked = 0;
      for (int i = 0; i < CELL_COUNT; i++) begin
        glyph_m[i] = GLYPH_SPACE; fg_m[i] = RST_FG; bg_m[i] = RST_BG;
        bold_m[i] = 0; trail_m[i] = 0;
      end
    endfunction

    function int at(int x, int y);
      if (x < 0 || y < 0 || x >= MAX_COLUMNS || y >= MAX_ROWS) return 0;
      return y * MAX_COLUMNS + x;
    endfunction

    function bit in_area(int x, int y);
      return x >= 0 && y >= 0 && x < cols && y < rows;
    endfunction

    function bit trail_at(int x, int y);
      return in_area(x, y) && trail_m[at(x, y)];
    endfunction

    function void blank(int x, int y);
      int i;
      if (!in_area(x, y)) return;
      i = at(x, y);
      glyph_m[i] = GLYPH_SPACE; fg_m[i] = dfg; bg_m[i] = dbg;
      bold_m[i] = 0; trail_m[i] = 0;
    endfunction

    function void clear_pair(int x, int y);
      if (!in_area(x, y)) return;
      if (trail_at(x, y)) begin
        blank(x, y); blank(x - 1, y);
      end else if (trail_at(x + 1, y)) begin
        blank(x, y); blank(x + 1, y);
      end else begin
        blank(x, y);
      end
    endfunction

    function void clear_span(int y, int x1, int x2);
      int t;
      if (y < 0 || y >= rows) return;
      if (x1 > x2) begin
        t = x1; x1 = x2; x2 = t;
      end
      if (x1 < 0) x1 = 0;
      if (x2 >= cols) x2 = cols - 1;
      for (int x = x1; x <= x2; x++) clear_pair(x, y);
    endfunction

    function int width_of(int c);
      bit east;
      bit ambig;
      if (c <= 'h7F) return 1;
      east = (c >= 'h1100 && c <= 'h11FF) || (c >= 'h3130 && c <= 'h318F) ||
             (c >= 'hAC00 && c <= 'hD7A3) || c == 'h3000 || (c >= 'h4E00 && c <= 'h9FFF);
      if (east) return 2;
      ambig = (c >= 'h2500 && c <= 'h257F) || (c >= 'h25A0 && c <= 'h25FF) ||
              (c >= 'h2190 && c <= 'h22FF) || (c >= 'h2460 && c <= 'h24FF) ||
              (c >= 'h2600 && c <= 'h27BF) || (c >= 'h2E80 && c <= 'hA4CF) ||
              (c >= 'hFE10 && c <= 'hFE19) || (c >= 'hFE30 && c <= 'hFE6F) ||
              (c >= 'hFF01 && c <= 'hFF60) || (c >= 'hFFE0 && c <= 'hFFE6);
      return (ambig && amb) ? 2 : 1;
    endfunction

    // bottom row keeps foreground and bold of what was there
    function void scroll_up();
      int d;
      int s;
      for (int y = 1; y < rows; y++)
        for (int x = 0; x < cols; x++) begin
          d = at(x, y - 1); s = at(x, y);
          glyph_m[d] = glyph_m[s]; fg_m[d] = fg_m[s]; bg_m[d] = bg_m[s];
          bold_m[d] = bold_m[s]; trail_m[d] = trail_m[s];
        end
      for (int x = 0; x < cols; x++) begin
        s = at(x, rows - 1);
        glyph_m[s] = GLYPH_SPACE; bg_m[s] = dbg; trail_m[s] = 0;
      end
    endfunction

    function void line_feed();
      cy++;
      if (cy >= rows) begin
        scroll_up(); cy = rows - 1;
      end
    endfunction

    function void normalize();
      if (cx < 0) cx = 0;
      if (cy < 0) cy = 0;
      if (cx >= cols) cx = cols - 1;
      if (cy >= rows) cy = rows - 1;
      if (cx > 0 && trail_at(cx, cy)) cx--;
    endfunction

    function void step_left(int n);
      for (int k = 0; k < n; k++) begin
        if (cx <= 0) begin
          cx = 0; break;
        end
        cx--;
        if (cx > 0 && trail_at(cx, cy)) cx--;
      end
    endfunction

    function void step_right(int n);
      for (int k = 0; k < n; k++) begin
        if (cx >= cols - 1) begin
          cx = cols - 1; break;
        end
        cx += trail_at(cx + 1, cy) ? 2 : 1;
        if (cx >= cols) cx = cols - 1;
      end
    endfunction

    function void put_glyph(logic [15:0] c, logic [23:0] fg, logic [23:0] bg, bit b);
      int w;
      int i;
      int stop;
      if (c == CH_CR) begin
        cx = 0; return;
      end
      if (c == CH_LF) begin
        line_feed(); return;
      end
      if (c == CH_BS) begin
        step_left(1); return;
      end
      if (c == CH_TAB) begin
        stop = (cx + TAB_STOP) & ~(TAB_STOP - 1);
        while (cx < stop && cx < cols - 1) step_right(1);
        return;
      end
      if (c < CH_FIRST_PRNT) return;
      normalize();
      w = width_of(int'(c));
      if (cx + w > cols) begin
        cx = 0; line_feed(); normalize();
      end
      clear_pair(cx, cy);
      if (w == 2 && cx + 1 < cols) clear_pair(cx + 1, cy);
      // wide glyph with no room for its right half: leave a blank
      if (w == 2 && cx + 1 >= cols) begin
        blank(cx, cy); return;
      end
      i = at(cx, cy);
      glyph_m[i] = c; fg_m[i] = fg; bg_m[i] = bg; bold_m[i] = b; trail_m[i] = 0;
      if (w == 2) begin
        i = at(cx + 1, cy);
        glyph_m[i] = GLYPH_SPACE; fg_m[i] = fg; bg_m[i] = bg; bold_m[i] = b;
        trail_m[i] = 1;
      end
      cx += w;
      if (cx >= cols) cx = cols - 1;
    endfunction

    function int clamp_pos(int a, int limit);
      int v;
      v = a - 1;
      if (v < 0) v = 0;
      if (v >= limit) v = limit - 1;
      return v;
    endfunction

    function void run_cmd(logic [7:0] letter, logic [15:0] a1, logic [15:0] a2);
      int n;
      n = (a1 == 0) ? 1 : int'(a1);
      case (letter)
        CMD_ERASE_SCR: begin
          if (a1 == ERASE_TO_END) begin
            clear_span(cy, cx, cols - 1);
            for (int y = cy + 1; y < rows; y++) clear_span(y, 0, cols - 1);
          end else if (a1 == ERASE_TO_START) begin
            for (int y = 0; y < cy; y++) clear_span(y, 0, cols - 1);
            clear_span(cy, 0, cx);
          end else if (a1 == ERASE_ALL) begin
            for (int y = 0; y < rows; y++) clear_span(y, 0, cols - 1);
            cx = 0; cy = 0;
          end
        end
        CMD_ERASE_LINE: begin
          if (a1 == ERASE_TO_END) clear_span(cy, cx, cols - 1);
          else if (a1 == ERASE_TO_START) clear_span(cy, 0, cx);
          else if (a1 == ERASE_ALL) clear_span(cy, 0, cols - 1);
        end
        CMD_POS, CMD_POS_ALT: begin
          cy = clamp_pos(n, rows);
          cx = clamp_pos((a2 == 0) ? 1 : int'(a2), cols);
          normalize();
        end
        CMD_UP: begin
          cy -= n; if (cy < 0) cy = 0; normalize();
        end
        CMD_DOWN: begin
          cy += n; if (cy >= rows) cy = rows - 1; normalize();
        end
        CMD_RIGHT: begin
          step_right(n); normalize();
        end
        CMD_LEFT: begin
          step_left(n); normalize();
        end
        CMD_COL, CMD_COL_ALT: begin
          cx = clamp_pos(n, cols); normalize();
        end
        CMD_ROW: begin
          cy = clamp_pos(n, rows); normalize();
        end
        default: ;
      endcase
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      int v;
      case (idx)
        REG_COLUMNS: begin
          v = int'(val[7:0]);
          cols = (v < 1) ? 1 : (v > MAX_COLUMNS) ? MAX_COLUMNS : v;
        end
        REG_ROWS: begin
          v = int'(val[6:0]);
          rows = (v < 1) ? 1 : (v > MAX_ROWS) ? MAX_ROWS : v;
        end
        REG_DEF_FG: dfg = val;
        REG_DEF_BG: dbg = val;
        REG_AMBIG: amb = val[0];
        default: return;
      endcase
      if (cx >= cols) cx = cols - 1;
      if (cy >= rows) cy = rows - 1;
    endfunction

    function void note_item(item_t it);
      result_t r;
      int i;
      r = '0;
      if (it.mode == MODE_PUT) begin
        put_glyph(it.char_code, it.text_color, it.paper_color, it.bold_flag);
      end else if (it.mode == MODE_CMD) begin
        run_cmd(it.command_letter, it.arg_first, it.arg_second);
      end else if (it.mode == MODE_READ) begin
        if (in_area(int'(it.read_column), int'(it.read_row))) begin
          i = at(int'(it.read_column), int'(it.read_row));
          r.cell_glyph = glyph_m[i]; r.cell_text_color = fg_m[i];
          r.cell_paper_color = bg_m[i]; r.cell_bold = bold_m[i];
          r.cell_is_trailer = trail_m[i];
        end else begin
          r.cell_glyph = GLYPH_SPACE; r.cell_text_color = dfg; r.cell_paper_color = dbg;
        end
      end
      r.cursor_column = cx[6:0];
      r.cursor_line = cy[5:0];
      due.insert(due.size(), r);
    endfunction

    function void check_result(result_t got);
      result_t e;
      checked++;
      if (due.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      e = due[0];
      due.delete(0);
      if (got.cell_glyph !== e.cell_glyph) begin
        $error("cell_glyph exp %h got %h", e.cell_glyph, got.cell_glyph); errors++;
      end
      if (got.cell_text_color !== e.cell_text_color) begin
        $error("cell_text_color exp %h got %h", e.cell_text_color, got.cell_text_color);
        errors++;
      end
      if (got.cell_paper_color !== e.cell_paper_color) begin
        $error("cell_paper_color exp %h got %h", e.cell_paper_color, got.cell_paper_color);
        errors++;
      end
      if (got.cell_bold !== e.cell_bold) begin
        $error("cell_bold exp %b got %b", e.cell_bold, got.cell_bold); errors++;
      end
      if (got.cell_is_trailer !== e.cell_is_trailer) begin
        $error("cell_is_trailer exp %b got %b", e.cell_is_trailer, got.cell_is_trailer);
        errors++;
      end
      if (got.cursor_column !== e.cursor_column) begin
        $error("cursor_column exp %0d got %0d", e.cursor_column, got.cursor_column); errors++;
      end
      if (got.cursor_line !== e.cursor_line) begin
        $error("cursor_line exp %0d got %0d", e.cursor_line, got.cursor_line); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit long_hold_req = 0;
  int hold_left = 0;
  screen_scoreboard sb = new();

  tcsw_item_if item_ch();
  tcsw_result_if res_ch();
  tcsw_cfg_if cfg_ch();

  terminal_cell_screen_writer_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch.sink),
    .result_o(res_ch.source),
    .cfg_i   (cfg_ch.sink)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: check each word, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
    if (long_hold_req) begin
      hold_left = 400;
      long_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // hold valid high between back-to-back words; drop it only for idle gaps
  task automatic send_item(item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  function automatic item_t mk_put(logic [15:0] c);
    item_t it;
    it = '0;
    it.mode = MODE_PUT;
    it.char_code = c;
    it.text_color = 24'($urandom);
    it.paper_color = 24'($urandom);
    it.bold_flag = 1'($urandom);
    return it;
  endfunction

  function automatic item_t mk_cmd(logic [7:0] letter, logic [15:0] a1, logic [15:0] a2);
    item_t it;
    it = '0;
    it.mode = MODE_CMD;
    it.command_letter = letter;
    it.arg_first = a1;
    it.arg_second = a2;
    return it;
  endfunction

  function automatic item_t mk_read(int x, int y);
    item_t it;
    it = '0;
    it.mode = MODE_READ;
    it.read_column = x[6:0];
    it.read_row = y[5:0];
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int roll;
    logic [7:0] letters [11];
    letters = '{CMD_ERASE_SCR, CMD_ERASE_LINE, CMD_POS, CMD_POS_ALT, CMD_UP, CMD_DOWN,
                CMD_RIGHT, CMD_LEFT, CMD_COL, CMD_COL_ALT, CMD_ROW};
    roll = $urandom_range(99);
    if (roll < 45) begin
      case ($urandom_range(9))
        0, 1, 2, 3: it = mk_put(16'($urandom_range('h7E, 'h20)));
        4: it = mk_put(16'($urandom_range('h9FFF, 'h4E00)));
        5: it = mk_put(16'($urandom_range('hD7A3, 'hAC00)));
        6: it = mk_put(16'($urandom_range('h25FF, 'h2190)));
        7: it = mk_put(16'($urandom_range('hFF60, 'hFE10)));
        8: it = mk_put(16'($urandom_range('h1F)));
        default: it = mk_put(16'($urandom));
      endcase
    end else if (roll < 75) begin
      it = mk_cmd(letters[$urandom_range(10)], 16'($urandom_range(3)),
                  16'($urandom_range(6)));
      if ($urandom_range(9) == 0) it.command_letter = 8'($urandom);
      case ($urandom_range(9))
        0: it.arg_first = 16'($urandom);
        1, 2: it.arg_first = 16'($urandom_range(140));
        default: ;
      endcase
      if ($urandom_range(4) == 0) it.arg_second = 16'($urandom);
      else if ($urandom_range(2) == 0) it.arg_second = 16'($urandom_range(140));
      it.text_color = 24'($urandom);
      it.paper_color = 24'($urandom);
      it.bold_flag = 1'($urandom);
    end else if (roll < 97) begin
      it = mk_read($urandom_range(sb.cols + 1), $urandom_range(sb.rows));
      if ($urandom_range(7) == 0) begin
        it.read_column = 7'($urandom);
        it.read_row = 6'($urandom);
      end
    end else begin
      it = mk_put(16'($urandom));
      it.mode = MODE_UNUSED;
    end
    if (it.mode != MODE_CMD && $urandom_range(3) == 0) begin
      it.command_letter = 8'($urandom);
      it.arg_first = 16'($urandom);
      it.arg_second = 16'($urandom);
    end
    return it;
  endfunction

  initial begin
    int ph_cols [8];
    int ph_rows [8];
    int ph_items [8];
    int settings;
    ph_cols = '{80, 255, 0, 16, 128, 8, 23, 40};
    ph_rows = '{32, 127, 0, 8, 2, 64, 5, 12};
    ph_items = '{40, 30, 25, 80, 40, 40, 80, 60};
    settings = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        drain();
        cfg_write(REG_COLUMNS, 24'($urandom) & 24'hFFFF00 | 24'(ph_cols[ph]));
        cfg_write(REG_ROWS, 24'(ph_rows[ph]));
        cfg_write(REG_DEF_FG, (ph == 6) ? 24'hFFFFFF : (ph == 7) ? 24'h0 : 24'($urandom));
        cfg_write(REG_DEF_BG, (ph == 6) ? 24'hFFFFFF : (ph == 7) ? 24'h0 : 24'($urandom));
        cfg_write(REG_AMBIG, 24'(ph % 2) | (24'($urandom) & 24'hFFFFFE));
        cfg_ch.valid <= 1'b0;
      end
      settings++;
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase

      if (ph == 0) begin
        send_item(mk_put(16'("A")));
        send_item(mk_put(16'h4E00));
        send_item(mk_put(16'h2500));
        send_item(mk_put(16'h0001));
        send_item(mk_put(16'hFFFF));
        send_item(mk_put(CH_BS));
        send_item(mk_put(CH_TAB));
        send_item(mk_read(1, 0));
        send_item(mk_read(2, 0));
        send_item(mk_put(CH_CR));
        send_item(mk_cmd(CMD_POS, 16'd0, 16'd0));
        send_item(mk_cmd(CMD_POS_ALT, 16'hFFFF, 16'hFFFF));
        send_item(mk_put(16'("Q")));
        send_item(mk_put(CH_LF));
        send_item(mk_read(79, 30));
        send_item(mk_read(127, 63));
        send_item(mk_cmd(CMD_UP, 16'd3, 16'd0));
        send_item(mk_cmd(CMD_DOWN, 16'd0, 16'd0));
        send_item(mk_cmd(CMD_LEFT, 16'hFFFF, 16'd0));
        send_item(mk_cmd(CMD_RIGHT, 16'd10, 16'd0));
        send_item(mk_cmd(CMD_COL, 16'd5, 16'd0));
        send_item(mk_cmd(CMD_COL_ALT, 16'd0, 16'd0));
        send_item(mk_cmd(CMD_ROW, 16'd4, 16'd0));
        send_item(mk_cmd(CMD_ERASE_LINE, 16'd3, 16'd0));
        send_item(mk_cmd("Z", 16'd1, 16'd1));
        send_item(mk_cmd(CMD_ERASE_LINE, ERASE_TO_START, 16'd0));
        send_item(mk_cmd(CMD_ERASE_SCR, ERASE_TO_END, 16'd0));
        send_item(mk_cmd(CMD_ERASE_SCR, ERASE_TO_START, 16'd0));
        send_item(mk_cmd(CMD_ERASE_SCR, ERASE_ALL, 16'd0));
      end else if (ph == 2) begin
        // wide glyph on a one-column screen
        send_item(mk_put(16'hAC00));
        send_item(mk_read(0, 0));
        send_item(mk_put(16'("x")));
        send_item(mk_read(0, 0));
      end

      for (int n = 0; n < ph_items[ph]; n++) begin
        if (ph == 3 && n == 20) long_hold_req = 1;
        send_item(rand_item());
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("Checked %0d result words across %0d screen settings in %0d cycles.",
             sb.checked, settings, cycles);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
